/* hw/rtl/i2cs_pkg.sv */
// Package for the I2C master transfer sequencer: command and result payload
// types, operation, state, error and notification codes. No dependencies.
package i2cs_pkg;

  // Command operation codes
  localparam logic [2:0] OP_START_WR = 3'd0;
  localparam logic [2:0] OP_START_RD = 3'd1;
  localparam logic [2:0] OP_SB       = 3'd2;
  localparam logic [2:0] OP_ADDR     = 3'd3;
  localparam logic [2:0] OP_TXE      = 3'd4;
  localparam logic [2:0] OP_RXNE     = 3'd5;
  localparam logic [2:0] OP_BTF      = 3'd6;
  localparam logic [2:0] OP_ERROR    = 3'd7;

  // Transfer state codes
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  // Error kinds
  localparam logic [2:0] ERR_BUS     = 3'd0;
  localparam logic [2:0] ERR_ARB     = 3'd1;
  localparam logic [2:0] ERR_ACKF    = 3'd2;
  localparam logic [2:0] ERR_OVR     = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;

  // Notification codes
  localparam logic [2:0] NTF_NONE     = 3'd0;
  localparam logic [2:0] NTF_TX_DONE  = 3'd1;
  localparam logic [2:0] NTF_RX_DONE  = 3'd2;
  localparam logic [2:0] NTF_BUS_ERR  = 3'd3;
  localparam logic [2:0] NTF_ARB_LOST = 3'd4;
  localparam logic [2:0] NTF_ACK_FAIL = 3'd5;
  localparam logic [2:0] NTF_OVERRUN  = 3'd6;
  localparam logic [2:0] NTF_TIMEOUT  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  slave_addr;
    logic [15:0] length;
    logic        repeat_start;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_data_in;
    logic        txe_flag;
    logic [2:0]  error_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  prev_state;
    logic        start_gen;
    logic        dr_write;
    logic [7:0]  dr_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [15:0] byte_index;
    logic        stop_gen;
    logic        ack_level;
    logic [2:0]  notify;
  } rsp_t;

endpackage

/* hw/rtl/i2cs_stream_if.sv */
// Valid/ready channel used for commands, results and configuration writes.
// Payload type is a parameter; depends on nothing else.
interface i2cs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer. Each command transaction on cmd (a start
// request or a peripheral event) yields exactly one result transaction on res.
// A command is taken into an input register and its result is computed in one
// pass and loaded into a result register, so one command per cycle is
// sustained; cmd.ready drops only while the result register is full and
// res.ready is low. The acknowledge default is written through cfg, by the user
// only while the block is idle (the block itself does not enforce this); it
// takes effect when the next reception completes.
// Depends on i2cs_pkg and i2cs_stream_if.
module i2c_master_transfer_sequencer
  import i2cs_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  i2cs_stream_if.sink   cmd,
  i2cs_stream_if.source res,
  i2cs_stream_if.sink   cfg
);

  localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_TWO  = LEN_BITS'(2);

  logic                ack_default;

  logic [1:0]          xfer_state, xfer_state_next;
  logic [6:0]          target_addr, target_addr_next;
  logic                hold_bus, hold_bus_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [LEN_BITS-1:0] read_total, read_total_next;
  logic [LEN_BITS-1:0] position, position_next;
  logic                ack_bit, ack_bit_next;

  logic                in_valid;
  cmd_t                in_q;
  logic                out_valid;
  rsp_t                out_q;
  rsp_t                rsp;
  logic                advance;
  logic [LEN_BITS-1:0] rx_left;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_default <= 1'b1;
    end else if (cfg.valid) begin
      ack_default <= cfg.data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_q <= cmd.data;
    end
  end

  // Sequencer step
  always_comb begin
    xfer_state_next  = xfer_state;
    target_addr_next = target_addr;
    hold_bus_next    = hold_bus;
    bytes_left_next  = bytes_left;
    read_total_next  = read_total;
    position_next    = position;
    ack_bit_next     = ack_bit;
    rx_left          = bytes_left;
    rsp              = '0;
    rsp.prev_state   = xfer_state;

    case (in_q.op)
      OP_START_WR, OP_START_RD: begin
        if (xfer_state == ST_READY) begin
          target_addr_next = in_q.slave_addr;
          bytes_left_next  = LEN_BITS'(in_q.length);
          hold_bus_next    = in_q.repeat_start;
          position_next    = LEN_ZERO;
          if (in_q.op == OP_START_RD) begin
            read_total_next = LEN_BITS'(in_q.length);
            xfer_state_next = ST_READ;
          end else begin
            xfer_state_next = ST_WRITE;
          end
          rsp.start_gen = 1'b1;
        end
      end
      OP_SB: begin
        if (xfer_state == ST_WRITE || xfer_state == ST_READ) begin
          rsp.dr_write = 1'b1;
          rsp.dr_byte  = {target_addr, (xfer_state == ST_READ)};
        end
      end
      OP_ADDR: begin
        // Single-byte read: NACK the only byte
        if (xfer_state == ST_READ && read_total == LEN_ONE) begin
          ack_bit_next = 1'b0;
        end
      end
      OP_TXE: begin
        if (xfer_state == ST_WRITE && bytes_left != LEN_ZERO) begin
          rsp.dr_write    = 1'b1;
          rsp.dr_byte     = in_q.tx_byte;
          rsp.byte_index  = 16'(position);
          bytes_left_next = bytes_left - LEN_ONE;
          position_next   = position + LEN_ONE;
        end
      end
      OP_RXNE: begin
        if (xfer_state == ST_READ) begin
          if (read_total != LEN_ZERO) begin
            // NACK ahead of the last byte
            if (read_total > LEN_ONE && bytes_left == LEN_TWO) begin
              ack_bit_next = 1'b0;
            end
            rsp.rx_valid   = 1'b1;
            rsp.rx_byte    = in_q.rx_data_in;
            rsp.byte_index = 16'(position);
            if (read_total > LEN_ONE) begin
              position_next = position + LEN_ONE;
            end
            if (bytes_left != LEN_ZERO) begin
              rx_left = bytes_left - LEN_ONE;
            end
          end
          bytes_left_next = rx_left;
          if (rx_left == LEN_ZERO) begin
            rsp.stop_gen    = !hold_bus;
            xfer_state_next = ST_READY;
            bytes_left_next = LEN_ZERO;
            read_total_next = LEN_ZERO;
            position_next   = LEN_ZERO;
            ack_bit_next    = ack_default;
            rsp.notify      = NTF_RX_DONE;
          end
        end
      end
      OP_BTF: begin
        if (xfer_state == ST_WRITE && in_q.txe_flag && bytes_left == LEN_ZERO) begin
          rsp.stop_gen    = !hold_bus;
          xfer_state_next = ST_READY;
          bytes_left_next = LEN_ZERO;
          read_total_next = LEN_ZERO;
          position_next   = LEN_ZERO;
          rsp.notify      = NTF_TX_DONE;
        end
      end
      OP_ERROR: begin
        case (in_q.error_kind)
          ERR_BUS:     rsp.notify = NTF_BUS_ERR;
          ERR_ARB:     rsp.notify = NTF_ARB_LOST;
          ERR_ACKF: begin
            rsp.notify = NTF_ACK_FAIL;
            // Abort a running transfer with STOP
            if (xfer_state != ST_READY) begin
              rsp.stop_gen    = 1'b1;
              xfer_state_next = ST_READY;
              bytes_left_next = LEN_ZERO;
              read_total_next = LEN_ZERO;
              position_next   = LEN_ZERO;
            end
          end
          ERR_OVR:     rsp.notify = NTF_OVERRUN;
          ERR_TIMEOUT: rsp.notify = NTF_TIMEOUT;
          default:     rsp.notify = NTF_NONE;
        endcase
      end
      default: begin
        rsp.notify = NTF_NONE;
      end
    endcase

    rsp.ack_level = ack_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_state  <= ST_READY;
      target_addr <= '0;
      hold_bus    <= 1'b0;
      bytes_left  <= LEN_ZERO;
      read_total  <= LEN_ZERO;
      position    <= LEN_ZERO;
      ack_bit     <= 1'b1;
    end else if (advance) begin
      xfer_state  <= xfer_state_next;
      target_addr <= target_addr_next;
      hold_bus    <= hold_bus_next;
      bytes_left  <= bytes_left_next;
      read_total  <= read_total_next;
      position    <= position_next;
      ack_bit     <= ack_bit_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= rsp;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (out_valid && !res.ready))
    else $error("command side stalled while result register can drain");

  a_idle_counts_clear: assert property (@(posedge clk) disable iff (rst)
    (xfer_state == ST_READY) |-> (bytes_left == LEN_ZERO && position == LEN_ZERO
                                  && read_total == LEN_ZERO))
    else $error("counts left over in ready state");

  a_start_from_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.start_gen) |-> (out_q.prev_state == ST_READY))
    else $error("START requested while a transfer was busy");

  a_stop_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.stop_gen) |-> (out_q.notify == NTF_TX_DONE
      || out_q.notify == NTF_RX_DONE || out_q.notify == NTF_ACK_FAIL))
    else $error("STOP requested without completion or abort");

  a_one_data_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_q.dr_write && out_q.rx_valid))
    else $error("data register write and reception in one result");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for i2c_master_transfer_sequencer: directed table, then random
// transfers under several idle/stall phases. Depends on i2cs_pkg and i2cs_stream_if.
module tb;
  import i2cs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIR = 24;
  localparam int ITEMS_PER_PHASE = 275;
  localparam logic [2:0] ERR_UNDEF = 3'd7;
  localparam rsp_t NO_EXP = '0;

  typedef struct packed {
    cmd_t c;
    logic chk;
    rsp_t e;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  i2cs_stream_if #(.T(cmd_t)) cmd_if ();
  i2cs_stream_if #(.T(rsp_t)) res_if ();
  i2cs_stream_if #(.T(logic)) cfg_if ();

  i2c_master_transfer_sequencer #(.LEN_BITS(16)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // Mirror of the sequencer state
  logic [1:0]  bus_state = ST_READY;
  logic [6:0]  tgt_addr = '0;
  logic        keep_bus = 1'b0;
  logic [15:0] left_cnt = '0;
  logic [15:0] rd_total = '0;
  logic [15:0] buf_pos = '0;
  logic        ack_now = 1'b1;
  logic        ack_dflt = 1'b1;

  rsp_t        pending_actions[$];
  logic        row_chk = 1'b0;
  rsp_t        row_exp = '0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  dir_row_t    dir_rows[N_DIR];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function void end_transfer();
    bus_state = ST_READY;
    left_cnt = '0;
    rd_total = '0;
    buf_pos = '0;
  endfunction

  function automatic rsp_t next_bus_action(cmd_t c);
    rsp_t r;
    r = '0;
    r.prev_state = bus_state;
    case (c.op)
      OP_START_WR, OP_START_RD: begin
        if (bus_state == ST_READY) begin
          tgt_addr = c.slave_addr;
          left_cnt = c.length;
          keep_bus = c.repeat_start;
          buf_pos = '0;
          if (c.op == OP_START_RD) begin
            rd_total = c.length;
            bus_state = ST_READ;
          end else begin
            bus_state = ST_WRITE;
          end
          r.start_gen = 1'b1;
        end
      end
      OP_SB: begin
        if (bus_state == ST_WRITE || bus_state == ST_READ) begin
          r.dr_write = 1'b1;
          r.dr_byte = {tgt_addr, bus_state == ST_READ};
        end
      end
      OP_ADDR: begin
        if (bus_state == ST_READ && rd_total == 16'd1) ack_now = 1'b0;
      end
      OP_TXE: begin
        if (bus_state == ST_WRITE && left_cnt != 0) begin
          r.dr_write = 1'b1;
          r.dr_byte = c.tx_byte;
          r.byte_index = buf_pos;
          left_cnt = left_cnt - 16'd1;
          buf_pos = buf_pos + 16'd1;
        end
      end
      OP_RXNE: begin
        if (bus_state == ST_READ) begin
          if (rd_total != 0) begin
            // NACK the last byte: clear ACK while the second-to-last arrives
            if (rd_total > 16'd1 && left_cnt == 16'd2) ack_now = 1'b0;
            r.rx_valid = 1'b1;
            r.rx_byte = c.rx_data_in;
            r.byte_index = buf_pos;
            if (rd_total > 16'd1) buf_pos = buf_pos + 16'd1;
            if (left_cnt != 0) left_cnt = left_cnt - 16'd1;
          end
          if (left_cnt == 0) begin
            r.stop_gen = !keep_bus;
            end_transfer();
            ack_now = ack_dflt;
            r.notify = NTF_RX_DONE;
          end
        end
      end
      OP_BTF: begin
        if (bus_state == ST_WRITE && c.txe_flag && left_cnt == 0) begin
          r.stop_gen = !keep_bus;
          end_transfer();
          r.notify = NTF_TX_DONE;
        end
      end
      default: begin
        if (c.error_kind <= ERR_TIMEOUT) begin
          r.notify = NTF_BUS_ERR + c.error_kind;
          if (c.error_kind == ERR_ACKF && bus_state != ST_READY) begin
            r.stop_gen = 1'b1;
            end_transfer();
          end
        end
      end
    endcase
    r.ack_level = ack_now;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (pending_actions.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got %0h", $time, got);
        end else begin
          want = pending_actions.pop_front();
          compare_field("prev_state", 16'(want.prev_state), 16'(got.prev_state));
          compare_field("start_gen", 16'(want.start_gen), 16'(got.start_gen));
          compare_field("dr_write", 16'(want.dr_write), 16'(got.dr_write));
          compare_field("dr_byte", 16'(want.dr_byte), 16'(got.dr_byte));
          compare_field("rx_valid", 16'(want.rx_valid), 16'(got.rx_valid));
          compare_field("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
          compare_field("byte_index", want.byte_index, got.byte_index);
          compare_field("stop_gen", 16'(want.stop_gen), 16'(got.stop_gen));
          compare_field("ack_level", 16'(want.ack_level), 16'(got.ack_level));
          compare_field("notify", 16'(want.notify), 16'(got.notify));
        end
      end
      if (cfg_if.valid && cfg_if.ready) ack_dflt = cfg_if.data;
      if (cmd_if.valid && cmd_if.ready) begin
        want = next_bus_action(cmd_if.data);
        pending_actions.push_back(row_chk ? row_exp : want);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_if.ready = ($urandom_range(99) >= stall_pct);
  end

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.op = 3'($urandom_range(7));
    c.slave_addr = 7'($urandom_range(127));
    c.length = 16'($urandom_range(65535));
    c.repeat_start = 1'($urandom_range(1));
    c.tx_byte = 8'($urandom_range(255));
    c.rx_data_in = 8'($urandom_range(255));
    c.txe_flag = 1'($urandom_range(1));
    c.error_kind = 3'($urandom_range(7));
    return c;
  endfunction

  // Mostly short lengths so a stray start does not lock the bus for long
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c = rand_cmd();
    if ($urandom_range(9) != 0) c.length = 16'($urandom_range(7));
    return c;
  endfunction

  task automatic send(cmd_t c, logic chk, rsp_t e);
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.data = c;
    row_chk = chk;
    row_exp = e;
    cmd_if.valid = 1'b1;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    cmd_if.valid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ack_default(logic v);
    cfg_if.data = v;
    cfg_if.valid = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // One transfer: start, SB, ADDR, data events, then completion or an abort
  task automatic run_transfer(output int n);
    cmd_t c;
    logic rd;
    int   len;
    int   body;
    int   cut;
    int   sel;
    int   i;
    rd = ($urandom_range(1) == 1);
    sel = $urandom_range(99);
    if (sel < 85) len = $urandom_range(5);
    else if (sel < 95) len = $urandom_range(20, 6);
    else len = $urandom_range(65535);
    body = (rd && len == 0) ? 1 : len;
    cut = -1;
    if (body > 24 || $urandom_range(99) < 8) cut = $urandom_range(body < 24 ? body : 24);
    n = 0;
    c = rand_cmd();
    c.op = rd ? OP_START_RD : OP_START_WR;
    c.length = 16'(len);
    send(c, 1'b0, NO_EXP);
    c = rand_cmd();
    c.op = OP_SB;
    send(c, 1'b0, NO_EXP);
    c = rand_cmd();
    c.op = OP_ADDR;
    send(c, 1'b0, NO_EXP);
    n += 3;
    for (i = 0; i < body && i != cut; i++) begin
      if ($urandom_range(99) < 5) send(noise_cmd(), 1'b0, NO_EXP);
      c = rand_cmd();
      c.op = rd ? OP_RXNE : OP_TXE;
      send(c, 1'b0, NO_EXP);
      n++;
    end
    if (cut >= 0) begin
      c = rand_cmd();
      c.op = OP_ERROR;
      c.error_kind = ERR_ACKF;
      send(c, 1'b0, NO_EXP);
      n++;
    end else if (!rd) begin
      if ($urandom_range(99) < 20) begin
        c = rand_cmd();
        c.op = OP_BTF;
        c.txe_flag = 1'b0;
        send(c, 1'b0, NO_EXP);
        n++;
      end
      if ($urandom_range(99) < 10) begin
        c = rand_cmd();
        c.op = OP_TXE;
        send(c, 1'b0, NO_EXP);
        n++;
      end
      c = rand_cmd();
      c.op = OP_BTF;
      c.txe_flag = 1'b1;
      send(c, 1'b0, NO_EXP);
      n++;
    end
  endtask

  initial begin : stimulus
    int done;
    int n;
    int p;
    int k;
    dir_rows[0] = '{'{OP_SB, 7'h00, 16'h0000, 1'b0, 8'hff, 8'hff, 1'b1, ERR_BUS}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[1] = '{'{OP_TXE, 7'h7f, 16'hffff, 1'b1, 8'hff, 8'h00, 1'b0, ERR_BUS}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[2] = '{'{OP_ERROR, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_ACKF}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1,
                      NTF_ACK_FAIL}};
    dir_rows[3] = '{'{OP_ERROR, 7'h7f, 16'hffff, 1'b1, 8'hff, 8'hff, 1'b1, ERR_UNDEF}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[4] = '{'{OP_ERROR, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1,
                      NTF_BUS_ERR}};
    dir_rows[5] = '{'{OP_ERROR, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_TIMEOUT}, 1'b1,
                    '{ST_READY, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1,
                      NTF_TIMEOUT}};
    dir_rows[6] = '{'{OP_START_WR, 7'h7f, 16'h0002, 1'b0, 8'hff, 8'h00, 1'b0, ERR_BUS}, 1'b1,
                    '{ST_READY, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[7] = '{'{OP_START_RD, 7'h00, 16'hffff, 1'b1, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b1,
                    '{ST_WRITE, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[8] = '{'{OP_SB, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b1,
                    '{ST_WRITE, 1'b0, 1'b1, 8'hfe, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, NTF_NONE}};
    dir_rows[9] = '{'{OP_ADDR, 7'h00, 16'h0001, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[10] = '{'{OP_TXE, 7'h00, 16'h0000, 1'b0, 8'hff, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[11] = '{'{OP_BTF, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b1, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[12] = '{'{OP_TXE, 7'h00, 16'h0000, 1'b0, 8'h00, 8'hff, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[13] = '{'{OP_TXE, 7'h00, 16'h0000, 1'b0, 8'h5a, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[14] = '{'{OP_BTF, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[15] = '{'{OP_BTF, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b1, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[16] = '{'{OP_START_RD, 7'h00, 16'h0001, 1'b1, 8'h00, 8'h00, 1'b0, ERR_BUS},
                     1'b0, NO_EXP};
    dir_rows[17] = '{'{OP_SB, 7'h7f, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[18] = '{'{OP_ADDR, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[19] = '{'{OP_RXNE, 7'h00, 16'h0000, 1'b0, 8'h00, 8'hff, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[20] = '{'{OP_START_RD, 7'h7f, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS},
                     1'b0, NO_EXP};
    dir_rows[21] = '{'{OP_RXNE, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_BUS}, 1'b0, NO_EXP};
    dir_rows[22] = '{'{OP_START_WR, 7'h55, 16'hffff, 1'b1, 8'h00, 8'h00, 1'b0, ERR_BUS},
                     1'b0, NO_EXP};
    dir_rows[23] = '{'{OP_ERROR, 7'h00, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b0, ERR_ACKF}, 1'b1,
                     '{ST_WRITE, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, 1'b1,
                       NTF_ACK_FAIL}};

    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < N_DIR; k++) send(dir_rows[k].c, dir_rows[k].chk, dir_rows[k].e);

    // Phases: no idling, sender idle, receiver stall, both; ACK default flips each time
    for (p = 0; p < 4; p++) begin
      wait_idle();
      write_ack_default(p % 2 == 1);
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        run_transfer(n);
        done += n;
        if ($urandom_range(99) < 10) send(noise_cmd(), 1'b0, NO_EXP);
      end
    end

    wait_idle();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
